>>> rtl/assert_macros.svh
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check an implication that applies only while a condition holds.
`define ASSERT_WHEN(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

`endif

>>> rtl/rvtc_pkg.sv
`default_nettype none
package rvtc_pkg;

    localparam int PRICE_BITS_DEF = 32;
    localparam int ACC_BITS_DEF   = 64;

    localparam int FRAC_BITS = 30;
    localparam int LOG_STEPS = 30;

    localparam logic [29:0] LN2_Q30       = 30'd744261118;
    localparam logic [31:0] VOL_SCALE_RST = 32'd1024000000;
    localparam logic [30:0] LN_MAX        = 31'h7FFF_FFFF;

    typedef enum logic [0:0] {
        CFG_PRICE_SOURCE = 1'b0,
        CFG_VOL_SCALE    = 1'b1
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NORM,
        ST_LOG,
        ST_DIFF,
        ST_MULLN,
        ST_RND,
        ST_SQ,
        ST_ACC,
        ST_CNT1,
        ST_CNT2,
        ST_CNT3,
        ST_FIN
    } state_t;

endpackage
`default_nettype wire

>>> rtl/realized_volatility_tick_counter.sv
// Flow: an item that is not ready or has a zero price goes straight to output;
//   otherwise it is normalized and sent through the serial log loop; its return
//   is scaled, rounded, squared and accumulated; a grown sum is counted, then output.
// Throughput: one item at a time, set by the serial normalize shift and the
//   one-squaring-per-cycle log loop; a result waits in its own register.
// Reset: async, control and sum state only; price_source 0, vol_scale 4000000.0.
`default_nettype none
module realized_volatility_tick_counter
    import rvtc_pkg::*;
#(
    parameter int PRICE_BITS = PRICE_BITS_DEF,
    parameter int ACC_BITS   = ACC_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] mid_price,
    input  wire logic [31:0] weighted_price,
    input  wire logic [62:0] event_time,
    input  wire logic        book_ready,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      tick_count,
    output logic [62:0]      update_time,
    output logic             updated
);

    localparam int NW    = (PRICE_BITS > 32) ? PRICE_BITS : 32;
    localparam int PW    = $clog2(PRICE_BITS);
    localparam int LW    = PW + FRAC_BITS;
    localparam int SHIFT = 68 - ACC_BITS;
    localparam int HIW   = ACC_BITS - 32;
    localparam logic [LW-1:0] MAG_MAX = LW'(3) << FRAC_BITS;

    state_t state_reg, state_next;

    logic                price_source_reg;
    logic [31:0]         vol_scale_reg;
    logic                have_prev_reg, have_prev_next;
    logic [LW-1:0]       prev_log_reg, prev_log_next;
    logic [ACC_BITS-1:0] acc_reg, acc_next;
    logic [31:0]         count_reg, count_next;
    logic [62:0]         change_time_reg, change_time_next;

    logic [NW-1:0]       norm_reg, norm_next;
    logic [PW-1:0]       exp_reg, exp_next;
    logic [31:0]         m_reg, m_next;
    logic [FRAC_BITS-1:0] frac_reg, frac_next;
    logic [4:0]          step_reg, step_next;
    logic [62:0]         time_reg, time_next;
    logic [31:0]         mag_reg, mag_next;
    logic [61:0]         prod_reg, prod_next;
    logic [30:0]         ln_reg, ln_next;
    logic [ACC_BITS-1:0] sq_reg, sq_next;
    logic                upd_reg, upd_next;
    logic [63:0]         plo_reg, plo_next;
    logic [ACC_BITS-1:0] phi_reg, phi_next;

    logic                out_valid_reg, out_valid_next;
    logic [31:0]         out_count_reg, out_count_next;
    logic [62:0]         out_time_reg, out_time_next;
    logic                out_upd_reg, out_upd_next;

    logic [31:0]           sel32;
    logic [PRICE_BITS+31:0] price_wide;
    logic [PRICE_BITS-1:0] price_in;
    logic [63:0]           m_sq;
    logic [32:0]           m_sh;
    logic [LW-1:0]         log_val;
    logic [LW-1:0]         diff;
    logic [62:0]           rnd_sum;
    logic [32:0]           ln_full;
    logic [61:0]           ln_sq;
    logic [ACC_BITS:0]     acc_sum;
    logic [64:0]           cnt_sum;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign tick_count  = out_count_reg;
    assign update_time = out_time_reg;
    assign updated     = out_upd_reg;

    assign sel32      = price_source_reg ? weighted_price : mid_price;
    assign price_wide = {PRICE_BITS'(0), sel32};
    assign price_in   = price_wide[PRICE_BITS-1:0];
    assign m_sq       = 64'(m_reg) * 64'(m_reg);
    assign m_sh       = m_sq[63:31];
    assign log_val    = {exp_reg, frac_reg};
    assign rnd_sum    = 63'(prod_reg) + (63'(1) << 29);
    assign ln_full    = rnd_sum[62:30];
    assign ln_sq      = 62'(ln_reg) * 62'(ln_reg);
    assign acc_sum    = {1'b0, acc_reg} + {1'b0, sq_reg};
    assign cnt_sum    = 65'(phi_reg) + 65'(plo_reg[63:32]);

    always_comb
    begin
        if (log_val >= prev_log_reg)
        begin
            diff = log_val - prev_log_reg;
        end
        else
        begin
            diff = prev_log_reg - log_val;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        have_prev_next   = have_prev_reg;
        prev_log_next    = prev_log_reg;
        acc_next         = acc_reg;
        count_next       = count_reg;
        change_time_next = change_time_reg;
        norm_next        = norm_reg;
        exp_next         = exp_reg;
        m_next           = m_reg;
        frac_next        = frac_reg;
        step_next        = step_reg;
        time_next        = time_reg;
        mag_next         = mag_reg;
        prod_next        = prod_reg;
        ln_next          = ln_reg;
        sq_next          = sq_reg;
        upd_next         = upd_reg;
        plo_next         = plo_reg;
        phi_next         = phi_reg;
        out_valid_next   = out_valid_reg;
        out_count_next   = out_count_reg;
        out_time_next    = out_time_reg;
        out_upd_next     = out_upd_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    time_next = event_time;
                    upd_next  = 1'b0;
                    norm_next = NW'(price_in) << (NW - PRICE_BITS);
                    exp_next  = PW'(PRICE_BITS - 1);
                    if (book_ready && (price_in != '0))
                    begin
                        state_next = ST_NORM;
                    end
                    else
                    begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_NORM:
            begin
                if (norm_reg[NW-1])
                begin
                    m_next     = norm_reg[NW-1 -: 32];
                    step_next  = '0;
                    state_next = ST_LOG;
                end
                else
                begin
                    norm_next = norm_reg << 1;
                    exp_next  = exp_reg - PW'(1);
                end
            end
            ST_LOG:
            begin
                if (m_sh[32])
                begin
                    m_next    = m_sh[32:1];
                    frac_next = {frac_reg[FRAC_BITS-2:0], 1'b1};
                end
                else
                begin
                    m_next    = m_sh[31:0];
                    frac_next = {frac_reg[FRAC_BITS-2:0], 1'b0};
                end
                step_next = step_reg + 5'd1;
                if (step_reg == 5'(LOG_STEPS - 1))
                begin
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF:
            begin
                mag_next       = (diff > MAG_MAX) ? 32'(MAG_MAX) : 32'(diff);
                prev_log_next  = log_val;
                have_prev_next = 1'b1;
                state_next     = have_prev_reg ? ST_MULLN : ST_FIN;
            end
            ST_MULLN:
            begin
                prod_next  = 62'(mag_reg) * 62'(LN2_Q30);
                state_next = ST_RND;
            end
            ST_RND:
            begin
                ln_next    = (ln_full > 33'(LN_MAX)) ? LN_MAX : ln_full[30:0];
                state_next = ST_SQ;
            end
            ST_SQ:
            begin
                sq_next    = ACC_BITS'(ln_sq >> SHIFT);
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                acc_next = acc_sum[ACC_BITS] ? '1 : acc_sum[ACC_BITS-1:0];
                if (acc_next > acc_reg)
                begin
                    upd_next         = 1'b1;
                    change_time_next = time_reg;
                    state_next       = ST_CNT1;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_CNT1:
            begin
                plo_next   = 64'(acc_reg[31:0]) * 64'(vol_scale_reg);
                state_next = ST_CNT2;
            end
            ST_CNT2:
            begin
                phi_next   = ACC_BITS'(HIW'(acc_reg[ACC_BITS-1:32]))
                             * ACC_BITS'(vol_scale_reg);
                state_next = ST_CNT3;
            end
            ST_CNT3:
            begin
                if (cnt_sum[64:ACC_BITS] != '0)
                begin
                    count_next = '1;
                end
                else
                begin
                    count_next = cnt_sum[ACC_BITS-1 -: 32];
                end
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_count_next = count_reg;
                    out_time_next  = change_time_reg;
                    out_upd_next   = upd_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            price_source_reg <= 1'b0;
            vol_scale_reg    <= VOL_SCALE_RST;
            have_prev_reg    <= 1'b0;
            prev_log_reg     <= '0;
            acc_reg          <= '0;
            count_reg        <= '0;
            change_time_reg  <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            have_prev_reg   <= have_prev_next;
            prev_log_reg    <= prev_log_next;
            acc_reg         <= acc_next;
            count_reg       <= count_next;
            change_time_reg <= change_time_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_PRICE_SOURCE: price_source_reg <= cfg_data[0];
                    CFG_VOL_SCALE:    vol_scale_reg    <= cfg_data;
                    default:          price_source_reg <= price_source_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        norm_reg      <= norm_next;
        exp_reg       <= exp_next;
        m_reg         <= m_next;
        frac_reg      <= frac_next;
        step_reg      <= step_next;
        time_reg      <= time_next;
        mag_reg       <= mag_next;
        prod_reg      <= prod_next;
        ln_reg        <= ln_next;
        sq_reg        <= sq_next;
        upd_reg       <= upd_next;
        plo_reg       <= plo_next;
        phi_reg       <= phi_next;
        out_count_reg <= out_count_next;
        out_time_reg  <= out_time_next;
        out_upd_reg   <= out_upd_next;
    end

`include "assert_macros.svh"

    `ASSERT_WHEN(a_log_normalized, state_reg == ST_LOG, m_reg[31], "mantissa not normalized")
    `ASSERT_CLK(a_acc_monotonic, 1'b1 |=> acc_reg >= $past(acc_reg), "accumulator decreased")
    `ASSERT_WHEN(a_upd_nonzero, out_valid_reg && out_upd_reg, acc_reg != '0, "update with empty acc")

endmodule
`default_nettype wire

>>> bench/volatility_checker.sv
module volatility_checker
    import rvtc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic [31:0] mid_price,
    input  wire logic [31:0] weighted_price,
    input  wire logic [62:0] event_time,
    input  wire logic        book_ready,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic [31:0] tick_count,
    input  wire logic [62:0] update_time,
    input  wire logic        updated,
    output int               pending,
    output int               fail_count,
    output int               update_total
);

    typedef struct packed {
        logic [31:0] count;
        logic [62:0] stamp;
        logic        grew;
    } tick_result_t;

    tick_result_t expected_ticks[$];

    logic        use_weighted;
    logic [31:0] scale_q8;
    logic        price_seen;
    logic [31:0] last_price;
    logic [63:0] var_sum;
    logic [63:0] var_peak;
    logic [31:0] count_now;
    logic [62:0] stamp_now;

    function automatic logic [63:0] log2_q30(input logic [31:0] x);
        int          msb;
        logic [63:0] m;
        logic [63:0] frac;
        msb = 0;
        frac = 0;
        for (int i = 0; i < 32; i++)
        begin
            if (x[i])
                msb = i;
        end
        m = {32'd0, x} << (31 - msb);
        for (int i = 0; i < 30; i++)
        begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= 64'h1_0000_0000)
            begin
                m = m >> 1;
                frac[0] = 1'b1;
            end
        end
        return (64'(msb) << 30) | frac;
    endfunction

    function automatic tick_result_t step_variance(input logic [31:0] mid,
                                                   input logic [31:0] wtd,
                                                   input logic [62:0] stamp,
                                                   input logic        ready);
        logic [31:0]  price;
        logic [63:0]  a;
        logic [63:0]  b;
        logic [63:0]  mag;
        logic [63:0]  ln;
        logic [63:0]  sq;
        logic [95:0]  prod;
        tick_result_t r;
        price = use_weighted ? wtd : mid;
        r.grew = 1'b0;
        if (ready && price != 0)
        begin
            if (price_seen)
            begin
                a = log2_q30(price);
                b = log2_q30(last_price);
                mag = (a >= b) ? a - b : b - a;
                if (mag > (64'd3 << 30))
                    mag = 64'd3 << 30;
                ln = (mag * 64'(LN2_Q30) + (64'd1 << 29)) >> 30;
                if (ln > 64'h7FFF_FFFF)
                    ln = 64'h7FFF_FFFF;
                sq = (ln * ln) >> 4;
                if (sq > ~var_sum)
                    var_sum = '1;
                else
                    var_sum = var_sum + sq;
            end
            price_seen = 1'b1;
            last_price = price;
            if (var_sum > var_peak)
            begin
                var_peak = var_sum;
                stamp_now = stamp;
                prod = 96'(var_sum) * 96'(scale_q8);
                count_now = prod[95:64];
                r.grew = 1'b1;
            end
        end
        r.count = count_now;
        r.stamp = stamp_now;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
        fail_count++;
    endtask

    assign pending = expected_ticks.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_ticks.delete();
            use_weighted = 1'b0;
            scale_q8 = VOL_SCALE_RST;
            price_seen = 1'b0;
            last_price = '0;
            var_sum = '0;
            var_peak = '0;
            count_now = '0;
            stamp_now = '0;
            fail_count = 0;
            update_total = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_PRICE_SOURCE)
                    use_weighted = cfg_data[0];
                else if (cfg_index == CFG_VOL_SCALE)
                    scale_q8 = cfg_data;
            end
            if (in_valid && in_ready)
                expected_ticks.push_back(step_variance(mid_price, weighted_price,
                                                       event_time, book_ready));
            if (out_valid && out_ready)
            begin
                if (expected_ticks.size() == 0)
                    report_mismatch("unexpected result, tick_count", tick_count, 0);
                else
                begin
                    tick_result_t w;
                    w = expected_ticks.pop_front();
                    if (tick_count !== w.count)
                        report_mismatch("tick_count", tick_count, w.count);
                    if (update_time !== w.stamp)
                        report_mismatch("update_time", update_time, w.stamp);
                    if (updated !== w.grew)
                        report_mismatch("updated", updated, w.grew);
                    if (w.grew)
                        update_total++;
                end
            end
        end
    end

endmodule

>>> bench/testbench.sv
module testbench;
    import rvtc_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_index = CFG_PRICE_SOURCE;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [31:0] mid_price = '0;
    logic [31:0] weighted_price = '0;
    logic [62:0] event_time = '0;
    logic        book_ready = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] tick_count;
    logic [62:0] update_time;
    logic        updated;

    int          pending;
    int          fail_count;
    int          update_total;
    int          sender_idle_pct = 0;
    int          receiver_idle_pct = 0;
    int          cycles = 0;
    int          sent = 0;
    logic [31:0] walk_price = 32'h0064_0000;
    logic [62:0] clock_stamp = 63'd1000;

    always #1 clk = ~clk;

    realized_volatility_tick_counter dut (.*);

    volatility_checker checker_i (.*);

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= receiver_idle_pct);
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic write_register(input cfg_index_t idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_event(input logic [31:0] mid, input logic [31:0] wtd,
                              input logic [62:0] stamp, input logic rdy);
        if ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        mid_price <= mid;
        weighted_price <= wtd;
        event_time <= stamp;
        book_ready <= rdy;
        do @(posedge clk); while (!in_ready);
        sent++;
    endtask

    task automatic settle;
        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic send_random_event;
        logic [31:0] step;
        logic [31:0] wtd;
        int          pick;
        pick = $urandom_range(99);
        step = $urandom_range(0, walk_price >> 6);
        walk_price = $urandom_range(1) ? walk_price + step : walk_price - step;
        if (pick < 4)
            walk_price = $urandom;
        if (walk_price == 0)
            walk_price = 32'd1;
        wtd = walk_price + $urandom_range(0, walk_price >> 8) - (walk_price >> 9);
        if (pick >= 4 && pick < 8)
            wtd = $urandom;
        clock_stamp = clock_stamp + $urandom_range(1, 5000);
        if ($urandom_range(99) < 2)
            clock_stamp = 63'({$urandom, $urandom});
        if (pick >= 90 && pick < 94)
            send_event(32'd0, 32'd0, clock_stamp, 1'b1);
        else
            send_event(walk_price, wtd, clock_stamp, pick < 96);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: no-op before first price, first price, extremes, clamp
        send_event(32'h0001_0000, 32'h0002_0000, 63'h7FFF_FFFF_FFFF_FFFF, 1'b0);
        send_event(32'd0, 32'hFFFF_FFFF, 63'd5, 1'b1);
        send_event(32'h0001_0000, 32'h0001_0000, 63'd0, 1'b1);
        send_event(32'h0001_0000, 32'd7, 63'd10, 1'b1);
        send_event(32'h0001_0001, 32'd0, 63'h7FFF_FFFF_FFFF_FFFF, 1'b1);
        send_event(32'hFFFF_FFFF, 32'hFFFF_FFFF, 63'h2AAA_AAAA_AAAA_AAAA, 1'b1);
        send_event(32'd1, 32'd1, 63'h5555_5555_5555_5555, 1'b1);
        send_event(32'd2, 32'h8000_0000, 63'd20, 1'b1);
        send_event(32'h8000_0000, 32'd3, 63'd30, 1'b0);
        send_event(32'h0000_8000, 32'd0, 63'd40, 1'b1);
        settle();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin write_register(CFG_PRICE_SOURCE, 32'd1);
                         write_register(CFG_VOL_SCALE, 32'hFFFF_FFFF); end
                1: begin write_register(CFG_PRICE_SOURCE, 32'd0);
                         write_register(CFG_VOL_SCALE, 32'd1); end
                2: begin write_register(CFG_PRICE_SOURCE, 32'd1);
                         write_register(CFG_VOL_SCALE, $urandom); end
                default: begin write_register(CFG_PRICE_SOURCE, 32'd0);
                               write_register(CFG_VOL_SCALE, VOL_SCALE_RST); end
            endcase
            sender_idle_pct = (phase % 3 == 0) ? 37 : (phase % 3 == 1) ? 65 : 0;
            receiver_idle_pct = (phase % 3 == 0) ? 65 : (phase % 3 == 1) ? 37 : 0;
            for (int n = 0; n < 150; n++)
                send_random_event();
            settle();
        end

        // drive the accumulator into saturation with full-scale swings
        for (int n = 0; n < 80; n++)
        begin
            clock_stamp = clock_stamp + 1;
            send_event(n[0] ? 32'hFFFF_FFFF : 32'd1, n[0] ? 32'd1 : 32'hFFFF_FFFF,
                       clock_stamp, 1'b1);
        end
        settle();

        $display("covered %0d events over five register settings and three idle mixes,",
                 sent);
        $display("%0d of them grew the variance sum, ending in saturation", update_total);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
